// ----- hdl/bgsa_pkg.sv -----
// bgsa_pkg: shared types and constants for the BEV grid scatter-accumulate block.
// Holds field widths, codes, controller state type and control/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bgsa_pkg;

	localparam int VAL_W   = 32;
	localparam int CNT_W   = 9;
	localparam int BCNT_W  = 4;
	localparam int IDX_W   = 8;
	localparam int BIDX_W  = 3;
	localparam int MODE_W  = 2;
	localparam int STS_W   = 2;
	localparam int CFG_IW  = 3;
	localparam int IN_DW   = 72;

	localparam logic [MODE_W-1:0] MODE_ACC   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

	localparam logic [STS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STS_W-1:0] STS_RANGE = 2'd1;
	localparam logic [STS_W-1:0] STS_SAT   = 2'd2;

	localparam logic [CFG_IW-1:0] REG_BATCH  = 3'd0;
	localparam logic [CFG_IW-1:0] REG_DEPTH  = 3'd1;
	localparam logic [CFG_IW-1:0] REG_HEIGHT = 3'd2;
	localparam logic [CFG_IW-1:0] REG_WIDTH  = 3'd3;
	localparam logic [CFG_IW-1:0] REG_CHAN   = 3'd4;

	localparam logic [1:0] STEP_LAST = 2'd3;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ADDR,
		S_READ,
		S_MODIFY,
		S_OUT
	} state_t;

	typedef struct packed {
		logic       clear;
		logic       load;
		logic       mul;
		logic [1:0] step;
		logic       rd;
		logic       err;
		logic       modify;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic addr_ok;
	} stat_t;

endpackage

`default_nettype wire

// ----- hdl/bgsa_ram.sv -----
// bgsa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bgsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/bgsa_datapath.sv -----
// bgsa_datapath: config registers, range check, iterative address build,
// grid RAM, saturating add and result/output registers.
// Depends on bgsa_pkg and bgsa_ram.
`timescale 1ns / 1ps
`default_nettype none

module bgsa_datapath
	import bgsa_pkg::*;
#(
	parameter int GRID_WORDS = 65536,
	parameter int MAX_DIM    = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CNT_W-1:0]  cfg_data,
	input  wire logic [IN_DW-1:0]  in_data,
	input  wire logic [MODE_W-1:0] in_mode,
	input  wire cmd_t              cmd,
	output stat_t                  stat,
	output logic      [VAL_W-1:0]  out_data,
	output logic      [STS_W-1:0]  out_status
);

	localparam int AW = $clog2(GRID_WORDS);
	localparam int PW = AW + CNT_W;
	localparam int SW = PW + 1;
	localparam logic [SW-1:0] LIM = SW'(GRID_WORDS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(GRID_WORDS - 1);
	localparam logic [12:0] MAXD = 13'(MAX_DIM);

	logic [BCNT_W-1:0] batch_cnt_q;
	logic [CNT_W-1:0]  depth_cnt_q, height_cnt_q, width_cnt_q, chan_cnt_q;
	logic [BCNT_W-1:0] eff_b;
	logic [CNT_W-1:0]  eff_d, eff_h, eff_w, eff_c;

	logic [BIDX_W-1:0] in_bi;
	logic [IDX_W-1:0]  in_di, in_ri, in_ci, in_chi;
	logic [VAL_W-1:0]  in_fv;

	logic [MODE_W-1:0] mode_q;
	logic [IDX_W-1:0]  di_q, ri_q, ci_q, chi_q;
	logic [VAL_W-1:0]  fv_q;
	logic              range_bad_q;
	logic [AW-1:0]     acc_q;
	logic              ovf_q;
	logic [AW-1:0]     clr_q;

	logic [CNT_W-1:0]  dim_sel;
	logic [IDX_W-1:0]  idx_sel;
	logic [PW-1:0]     prod;
	logic [SW-1:0]     sum;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [VAL_W-1:0]  ram_wdata;
	logic [VAL_W-1:0]  rdata;

	logic [VAL_W:0]    add33;
	logic              sat;
	logic [VAL_W-1:0]  acc_val;
	logic [VAL_W-1:0]  new_val;
	logic [STS_W-1:0]  new_sts;

	logic [VAL_W-1:0]  res_val_q;
	logic [STS_W-1:0]  res_sts_q;
	logic [VAL_W-1:0]  out_val_q;
	logic [STS_W-1:0]  out_sts_q;

	assign in_bi  = in_data[2:0];
	assign in_di  = in_data[10:3];
	assign in_ri  = in_data[18:11];
	assign in_ci  = in_data[26:19];
	assign in_chi = in_data[34:27];
	assign in_fv  = in_data[66:35];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_cnt_q  <= 4'd1;
			depth_cnt_q  <= 9'd1;
			height_cnt_q <= 9'd16;
			width_cnt_q  <= 9'd16;
			chan_cnt_q   <= 9'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BATCH:  batch_cnt_q  <= cfg_data[BCNT_W-1:0];
				REG_DEPTH:  depth_cnt_q  <= cfg_data;
				REG_HEIGHT: height_cnt_q <= cfg_data;
				REG_WIDTH:  width_cnt_q  <= cfg_data;
				REG_CHAN:   chan_cnt_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// counts above MAX_DIM act as MAX_DIM
	assign eff_b = ({9'd0, batch_cnt_q} > MAXD) ? MAXD[BCNT_W-1:0] : batch_cnt_q;
	assign eff_d = ({4'd0, depth_cnt_q} > MAXD) ? MAXD[CNT_W-1:0] : depth_cnt_q;
	assign eff_h = ({4'd0, height_cnt_q} > MAXD) ? MAXD[CNT_W-1:0] : height_cnt_q;
	assign eff_w = ({4'd0, width_cnt_q} > MAXD) ? MAXD[CNT_W-1:0] : width_cnt_q;
	assign eff_c = ({4'd0, chan_cnt_q} > MAXD) ? MAXD[CNT_W-1:0] : chan_cnt_q;

	always_comb begin
		case (cmd.step)
			2'd0: begin
				dim_sel = eff_d;
				idx_sel = di_q;
			end
			2'd1: begin
				dim_sel = eff_h;
				idx_sel = ri_q;
			end
			2'd2: begin
				dim_sel = eff_w;
				idx_sel = ci_q;
			end
			default: begin
				dim_sel = eff_c;
				idx_sel = chi_q;
			end
		endcase
	end

	assign prod = PW'(acc_q) * PW'(dim_sel);
	assign sum  = SW'(prod) + SW'(idx_sel);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			di_q   <= in_di;
			ri_q   <= in_ri;
			ci_q   <= in_ci;
			chi_q  <= in_chi;
			fv_q   <= in_fv;
			acc_q  <= AW'(in_bi);
			range_bad_q <= ({1'b0, in_bi} >= eff_b) || ({1'b0, in_di} >= eff_d) ||
				({1'b0, in_ri} >= eff_h) || ({1'b0, in_ci} >= eff_w) ||
				({1'b0, in_chi} >= eff_c);
		end else if (cmd.mul) begin
			acc_q <= sum[AW-1:0];
		end
	end

	// once the partial address reaches the store size the overflow flag stays set until the next load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (cmd.load) begin
			ovf_q <= 1'b0;
		end else if (cmd.mul) begin
			ovf_q <= ovf_q || (sum >= LIM);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	assign stat.clr_last = (clr_q == LAST_ADDR);
	assign stat.addr_ok  = !range_bad_q && !ovf_q;

	assign add33   = {rdata[VAL_W-1], rdata} + {fv_q[VAL_W-1], fv_q};
	assign sat     = add33[VAL_W] != add33[VAL_W-1];
	assign acc_val = sat ? (add33[VAL_W] ? 32'h8000_0000 : 32'h7FFF_FFFF)
		: add33[VAL_W-1:0];

	always_comb begin
		case (mode_q)
			MODE_ACC: begin
				new_val = acc_val;
				new_sts = sat ? STS_SAT : STS_OK;
			end
			MODE_WRITE: begin
				new_val = fv_q;
				new_sts = STS_OK;
			end
			default: begin
				new_val = rdata;
				new_sts = STS_OK;
			end
		endcase
	end

	assign ram_we    = cmd.clear ||
		(cmd.modify && (mode_q inside {MODE_ACC, MODE_WRITE}));
	assign ram_waddr = cmd.clear ? clr_q : acc_q;
	assign ram_wdata = cmd.clear ? '0 : new_val;

	bgsa_ram #(
		.WIDTH (VAL_W),
		.DEPTH (GRID_WORDS)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd),
		.raddr (acc_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.err) begin
			res_val_q <= '0;
			res_sts_q <= STS_RANGE;
		end else if (cmd.modify) begin
			res_val_q <= new_val;
			res_sts_q <= new_sts;
		end
		if (cmd.out_load) begin
			out_val_q <= res_val_q;
			out_sts_q <= res_sts_q;
		end
	end

	assign out_data   = out_val_q;
	assign out_status = out_sts_q;

endmodule

`default_nettype wire

// ----- hdl/bgsa_ctrl.sv -----
// bgsa_ctrl: controller FSM for the BEV grid scatter-accumulate block.
// Sequences the clear sweep, address steps, RAM access and output register.
// Depends on bgsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bgsa_ctrl
	import bgsa_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t     state_q, state_d;
	logic [1:0] step_q;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.step = step_q;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_ADDR;
				end
			end
			S_ADDR: begin
				cmd.mul = 1'b1;
				if (step_q == STEP_LAST) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (stat.addr_ok) begin
					cmd.rd  = 1'b1;
					state_d = S_MODIFY;
				end else begin
					cmd.err = 1'b1;
					state_d = S_OUT;
				end
			end
			S_MODIFY: begin
				cmd.modify = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				step_q <= 2'd0;
			end else if (cmd.mul) begin
				step_q <= step_q + 2'd1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	logic rd_cmd, modify_cmd;
	assign rd_cmd     = cmd.rd;
	assign modify_cmd = cmd.modify;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while held");

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_cmd |-> stat.addr_ok)
		else $error("grid read issued for an out-of-range address");

	a_modify_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		modify_cmd |-> $past(rd_cmd))
		else $error("modify without a preceding read");

	a_accept_starts_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_ADDR && step_q == 2'd0))
		else $error("accepted transaction did not start address build");

endmodule

`default_nettype wire

// ----- hdl/bev_grid_scatter_accumulate.sv -----
// bev_grid_scatter_accumulate: top level of the BEV grid scatter-accumulate block.
// Instantiates bgsa_ctrl and bgsa_datapath; uses bgsa_pkg.
//
// Channel   Dir  Signals                         Contents
// s_axis    in   tvalid/tready/tdata[71:0]/tuser  one grid element operation
// m_axis    out  tvalid/tready/tdata[31:0]/tuser  entry value and status
// cfg       in   cfg_we/cfg_index/cfg_data        grid dimension registers
//
// Each transaction holds the block from acceptance to its output register load: the
// accepting edge captures it, four multiply-add steps through one 16x9 multiplier
// (address width by count width) build the address, then a RAM read, a read-modify-write
// and the output register load, which raises m_axis_tvalid. An out-of-range transaction
// skips the RAM. s_axis_tready is high only while the controller is idle.
// After reset the grid RAM is swept to zero, one word a cycle, all GRID_WORDS words, while
// s_axis_tready stays low. A stalled m_axis holds the next result in the datapath result
// register while the controller waits for the output register to free.
`timescale 1ns / 1ps
`default_nettype none

module bev_grid_scatter_accumulate
	import bgsa_pkg::*;
#(
	parameter int GRID_WORDS = 65536,
	parameter int MAX_DIM    = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	// batch_index[2:0], depth_index[10:3], row_index[18:11], col_index[26:19],
	// channel_index[34:27], feature_value[66:35], zero pad[71:67]
	input  wire logic [IN_DW-1:0]  s_axis_tdata,
	// mode[1:0]
	input  wire logic [MODE_W-1:0] s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// entry_value[31:0]
	output logic      [VAL_W-1:0]  m_axis_tdata,
	// status[1:0]
	output logic      [STS_W-1:0]  m_axis_tuser,
	input  wire logic              cfg_we,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CNT_W-1:0]  cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	bgsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bgsa_datapath #(
		.GRID_WORDS (GRID_WORDS),
		.MAX_DIM    (MAX_DIM)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_data    (s_axis_tdata),
		.in_mode    (s_axis_tuser),
		.cmd        (cmd),
		.stat       (stat),
		.out_data   (m_axis_tdata),
		.out_status (m_axis_tuser)
	);

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// testbench: self-checking bench for bev_grid_scatter_accumulate.
// Predicts every result from its own copy of the grid and the dimension registers.
// Depends on bgsa_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module testbench;
	import bgsa_pkg::*;

	localparam int GRID_WORDS = 65536;
	localparam int MAX_DIM    = 256;
	localparam int IDLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 170;

	localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;
	localparam logic [CFG_IW-1:0] REG_SPARE_A = 3'd5;
	localparam logic [CFG_IW-1:0] REG_SPARE_B = 3'd6;
	localparam logic [CFG_IW-1:0] REG_SPARE_C = 3'd7;
	localparam logic [VAL_W-1:0]  SAT_HI = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0]  SAT_LO = 32'h8000_0000;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [BIDX_W-1:0] bi;
		logic [IDX_W-1:0]  di;
		logic [IDX_W-1:0]  ri;
		logic [IDX_W-1:0]  ci;
		logic [IDX_W-1:0]  chi;
		logic [VAL_W-1:0]  fv;
	} op_t;

	class grid_scoreboard;
		typedef struct {
			logic [VAL_W-1:0] value;
			logic [STS_W-1:0] status;
		} entry_t;

		int unsigned counts[5];
		logic [VAL_W-1:0] grid[GRID_WORDS];
		entry_t awaited[$];
		int unsigned failures;

		function new();
			counts = '{1, 1, 16, 16, 64};
			foreach (grid[i]) grid[i] = '0;
			failures = 0;
		endfunction

		function void write_reg(logic [CFG_IW-1:0] idx, logic [CNT_W-1:0] data);
			case (idx)
				REG_BATCH:  counts[0] = data[BCNT_W-1:0];
				REG_DEPTH:  counts[1] = data;
				REG_HEIGHT: counts[2] = data;
				REG_WIDTH:  counts[3] = data;
				REG_CHAN:   counts[4] = data;
				default: ;
			endcase
		endfunction

		function int unsigned effective(int k);
			return (counts[k] > MAX_DIM) ? MAX_DIM : counts[k];
		endfunction

		// all ones when a coordinate is out of range
		function longint unsigned element_addr(op_t it);
			longint unsigned a;
			if (it.bi >= effective(0) || it.di >= effective(1) || it.ri >= effective(2) ||
				it.ci >= effective(3) || it.chi >= effective(4))
				return '1;
			a = it.bi;
			a = a * effective(1) + it.di;
			a = a * effective(2) + it.ri;
			a = a * effective(3) + it.ci;
			a = a * effective(4) + it.chi;
			return a;
		endfunction

		function void note_input(op_t it);
			longint unsigned a;
			logic signed [VAL_W:0] total;
			entry_t r;
			a = element_addr(it);
			r.status = STS_OK;
			if (a >= GRID_WORDS) begin
				r.value = '0;
				r.status = STS_RANGE;
			end else begin
				case (it.mode)
					MODE_ACC: begin
						total = $signed({grid[a][VAL_W-1], grid[a]}) +
							$signed({it.fv[VAL_W-1], it.fv});
						if (total[VAL_W] != total[VAL_W-1]) begin
							r.value = total[VAL_W] ? SAT_LO : SAT_HI;
							r.status = STS_SAT;
						end else begin
							r.value = total[VAL_W-1:0];
						end
						grid[a] = r.value;
					end
					MODE_WRITE: begin
						grid[a] = it.fv;
						r.value = it.fv;
					end
					default: r.value = grid[a];
				endcase
			end
			awaited.push_back(r);
		endfunction

		function void check_result(logic [VAL_W-1:0] value, logic [STS_W-1:0] status);
			entry_t e;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result entry_value %h status %0d", $time, value, status);
				failures++;
				return;
			end
			e = awaited.pop_front();
			if (value !== e.value) begin
				$display("%0t: entry_value expected %h actual %h", $time, e.value, value);
				failures++;
			end
			if (status !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, status);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_DW-1:0] s_axis_tdata;
	logic [MODE_W-1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [VAL_W-1:0] m_axis_tdata;
	logic [STS_W-1:0] m_axis_tuser;
	logic cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CNT_W-1:0] cfg_data;

	grid_scoreboard sb;
	int tx_idle_pct;
	int rx_idle_pct;

	bev_grid_scatter_accumulate #(
		.GRID_WORDS(GRID_WORDS),
		.MAX_DIM   (MAX_DIM)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// cycles without any transaction on either stream
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("testbench: errors");
		$finish;
	end

	function automatic op_t mk(logic [MODE_W-1:0] mode, int unsigned bi, di, ri, ci, chi,
		logic [VAL_W-1:0] fv);
		op_t it;
		it.mode = mode;
		it.bi = BIDX_W'(bi);
		it.di = IDX_W'(di);
		it.ri = IDX_W'(ri);
		it.ci = IDX_W'(ci);
		it.chi = IDX_W'(chi);
		it.fv = fv;
		return it;
	endfunction

	function automatic int unsigned pick_coord(int unsigned eff, int unsigned span, bit hot);
		int unsigned hi;
		hi = (eff < span) ? eff : span;
		if (hot && hi > 2)
			hi = 2;
		return (hi == 0) ? 0 : $urandom_range(hi - 1);
	endfunction

	function automatic op_t random_op();
		op_t it;
		bit hot;
		case ($urandom_range(3))
			0: it.fv = $urandom;
			1: it.fv = $urandom_range(32'h3FFFF) - 32'h20000;
			2: it.fv = $urandom_range(1) ? SAT_HI - $urandom_range(32'hFFFFF) :
				SAT_LO + $urandom_range(32'hFFFFF);
			default: begin
				case ($urandom_range(2))
					0: it.fv = SAT_HI;
					1: it.fv = SAT_LO;
					default: it.fv = '0;
				endcase
			end
		endcase
		// noise: any mode, any coordinates
		if ($urandom_range(99) < 15) begin
			it.mode = MODE_W'($urandom_range(3));
			it.bi = BIDX_W'($urandom);
			it.di = IDX_W'($urandom);
			it.ri = IDX_W'($urandom);
			it.ci = IDX_W'($urandom);
			it.chi = IDX_W'($urandom);
			return it;
		end
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: it.mode = MODE_ACC;
			6, 7: it.mode = MODE_WRITE;
			8: it.mode = MODE_READ;
			default: it.mode = ($urandom_range(3) == 0) ? MODE_SPARE : MODE_READ;
		endcase
		// hot picks keep hitting a few entries so sums build up and saturate
		hot = ($urandom_range(1) == 1);
		for (int t = 0; t < 16; t++) begin
			it.bi = BIDX_W'(pick_coord(sb.effective(0), 8, hot));
			it.di = IDX_W'(pick_coord(sb.effective(1), 256, hot));
			it.ri = IDX_W'(pick_coord(sb.effective(2), 256, hot));
			it.ci = IDX_W'(pick_coord(sb.effective(3), 256, hot));
			it.chi = IDX_W'(pick_coord(sb.effective(4), 256, hot));
			if (sb.element_addr(it) < GRID_WORDS)
				break;
		end
		return it;
	endfunction

	task automatic send(input op_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_DW'({it.fv, it.chi, it.ci, it.ri, it.di, it.bi});
		s_axis_tuser <= it.mode;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(it);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
	endtask

	task automatic configure(input int unsigned b, d, h, w, c, input bit spare);
		logic [CFG_IW-1:0] idx[$];
		logic [CNT_W-1:0] val[$];
		if (spare) begin
			idx.push_back(REG_SPARE_A);
			val.push_back(9'h1FF);
			idx.push_back(REG_SPARE_B);
			val.push_back(9'h000);
			idx.push_back(REG_SPARE_C);
			val.push_back(9'h155);
		end
		idx.push_back(REG_BATCH);
		val.push_back(CNT_W'(b));
		idx.push_back(REG_DEPTH);
		val.push_back(CNT_W'(d));
		idx.push_back(REG_HEIGHT);
		val.push_back(CNT_W'(h));
		idx.push_back(REG_WIDTH);
		val.push_back(CNT_W'(w));
		idx.push_back(REG_CHAN);
		val.push_back(CNT_W'(c));
		foreach (idx[k]) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= val[k];
			@(posedge clk);
			sb.write_reg(idx[k], val[k]);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned dims[6][5];
		dims = '{'{2, 4, 8, 8, 16}, '{1, 1, 1, 1, 1}, '{511, 511, 511, 511, 511},
			'{8, 2, 32, 32, 32}, '{3, 5, 7, 9, 11}, '{4, 3, 10, 6, 200}};
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = MODE_ACC;
		cfg_we = 1'b0;
		cfg_index = REG_BATCH;
		cfg_data = '0;
		tx_idle_pct = 38;
		rx_idle_pct = 61;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset dimensions: 1 x 1 x 16 x 16 x 64
		send(mk(MODE_WRITE, 0, 0, 0, 0, 0, 32'h7FFF_0000));
		send(mk(MODE_ACC, 0, 0, 0, 0, 0, 32'h0002_0000));
		send(mk(MODE_READ, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
		send(mk(MODE_WRITE, 0, 0, 15, 15, 63, 32'h8000_0001));
		send(mk(MODE_ACC, 0, 0, 15, 15, 63, 32'hFFFF_FFFE));
		send(mk(MODE_SPARE, 0, 0, 15, 15, 63, 32'h1234_5678));
		send(mk(MODE_ACC, 0, 0, 3, 4, 5, 32'h0001_8000));
		send(mk(MODE_ACC, 0, 0, 3, 4, 5, 32'hFFFF_0000));
		send(mk(MODE_ACC, 7, 0, 0, 0, 0, 32'h0001_0000));
		send(mk(MODE_ACC, 0, 255, 0, 0, 0, 32'h0001_0000));
		send(mk(MODE_WRITE, 0, 0, 16, 0, 0, 32'h0001_0000));
		send(mk(MODE_READ, 0, 0, 0, 255, 0, 32'h0));
		send(mk(MODE_ACC, 0, 0, 0, 0, 64, 32'h0001_0000));
		send(mk(MODE_READ, 0, 0, 1, 1, 1, 32'h0));
		drain();

		// zero batch count: nothing is in range
		configure(0, 1, 16, 16, 64, 1'b1);
		send(mk(MODE_ACC, 0, 0, 0, 0, 0, 32'h0001_0000));
		drain();

		// counts above the maximum act as the maximum; address past the store
		configure(1, 511, 511, 511, 511, 1'b0);
		send(mk(MODE_WRITE, 0, 0, 0, 255, 255, 32'h5A5A_A5A5));
		send(mk(MODE_READ, 0, 0, 0, 255, 255, 32'h0));
		send(mk(MODE_ACC, 0, 0, 1, 0, 0, 32'h0001_0000));
		send(mk(MODE_ACC, 0, 255, 255, 255, 255, 32'h0001_0000));
		send(mk(MODE_ACC, 0, 0, 0, 255, 255, 32'h8000_0000));

		for (int p = 0; p < 6; p++) begin
			drain();
			configure(dims[p][0], dims[p][1], dims[p][2], dims[p][3], dims[p][4], p == 2);
			if (p < 2) begin
				tx_idle_pct = 38;
				rx_idle_pct = 61;
			end else if (p < 4) begin
				tx_idle_pct = 61;
				rx_idle_pct = 38;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			repeat (PHASE_ITEMS) send(random_op());
		end
		drain();
		repeat (20) @(posedge clk);
		if (sb.failures == 0 && sb.awaited.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/bgsa_pkg.sv
hdl/bgsa_ram.sv
hdl/bgsa_datapath.sv
hdl/bgsa_ctrl.sv
hdl/bev_grid_scatter_accumulate.sv
test/testbench.sv
